// ===== rtl/at_sms_response_parser_unit_defines.svh =====
// Assertion macros used by the parser back end.
`ifndef AT_SMS_RESPONSE_PARSER_UNIT_DEFINES_SVH
`define AT_SMS_RESPONSE_PARSER_UNIT_DEFINES_SVH

// The condition holds at every rising clock edge outside reset.
`define ATSMS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequence holds in the cycle after the antecedent.
`define ATSMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/atsms_pkg.sv =====
// Types, codes and keyword tables of the modem response parser.
package atsms_pkg;

	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_FIELD_CHAR = 3'd1,
		EV_FIELD_END  = 3'd2,
		EV_WIFI_DONE  = 3'd3,
		EV_REG_DONE   = 3'd4,
		EV_MSG_SENT   = 3'd5,
		EV_ABORTED    = 3'd6,
		EV_HEADER     = 3'd7
	} event_t;

	localparam logic [1:0] FLD_SENDER  = 2'd0;
	localparam logic [1:0] FLD_STAMP   = 2'd1;
	localparam logic [1:0] FLD_COMMAND = 2'd2;
	localparam logic [1:0] FLD_DATA    = 2'd3;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_TEXT = 2'd1;
	localparam logic [1:0] KIND_SENT = 2'd2;

	localparam logic [3:0] STEP_IDLE       = 4'd0;
	localparam logic [3:0] STEP_HEAD       = 4'd1;
	localparam logic [3:0] STEP_SENDER     = 4'd2;
	localparam logic [3:0] STEP_SKIP_FIRST = 4'd3;
	localparam logic [3:0] STEP_SKIP_LAST  = 4'd5;
	localparam logic [3:0] STEP_STAMP      = 4'd6;
	localparam logic [3:0] STEP_LINE_END   = 4'd7;
	localparam logic [3:0] STEP_COMMAND    = 4'd8;
	localparam logic [3:0] STEP_DATA       = 4'd9;

	// Steps of a send result, which reuse the step register after its header.
	localparam logic [3:0] STEP_SENT_CR1 = 4'd1;
	localparam logic [3:0] STEP_SENT_LF1 = 4'd2;
	localparam logic [3:0] STEP_SENT_CR2 = 4'd3;
	localparam logic [3:0] STEP_SENT_LF2 = 4'd4;
	localparam logic [3:0] STEP_SENT_O   = 4'd5;
	localparam logic [3:0] STEP_SENT_K   = 4'd6;

	localparam logic [2:0] HDR_NONE  = 3'd0;
	localparam logic [2:0] HDR_PLUS  = 3'd1;
	localparam logic [2:0] HDR_C     = 3'd2;
	localparam logic [2:0] HDR_M     = 3'd3;
	localparam logic [2:0] HDR_KIND  = 3'd4;
	localparam logic [2:0] HDR_FIVE  = 3'd5;
	localparam logic [2:0] HDR_SIX   = 3'd6;

	localparam logic [5:0] WIFI_LEN = 6'd11;
	localparam logic [5:0] REG_LEN  = 6'd29;
	localparam logic [5:0] KW_POS_MAX = 6'd63;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [7:0] ch;
		logic is_plus;
		logic is_c;
		logic is_m;
		logic is_t;
		logic is_g;
		logic is_s;
		logic is_colon;
		logic is_quote;
		logic is_cr;
		logic is_lf;
		logic is_o;
		logic is_k;
	} byte_class_t;

	function automatic logic [7:0] wifi_char(input logic [5:0] pos);
		logic [7:0] r;
		case (pos)
			6'd0: r = "W";
			6'd1: r = "i";
			6'd2: r = "F";
			6'd3: r = "i";
			6'd4: r = "C";
			6'd5: r = "o";
			6'd6: r = "n";
			6'd7: r = "n";
			6'd8: r = "e";
			6'd9: r = "c";
			6'd10: r = "t";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] reg_char(input logic [5:0] pos);
		logic [7:0] r;
		case (pos)
			6'd0: r = "P";
			6'd1: r = "L";
			6'd2: r = "M";
			6'd3: r = "S";
			6'd4: r = "-";
			6'd5: r = "U";
			6'd6: r = "n";
			6'd7: r = "i";
			6'd8: r = "t";
			6'd9: r = "R";
			6'd10: r = "e";
			6'd11: r = "g";
			6'd12: r = "i";
			6'd13: r = "s";
			6'd14: r = "t";
			6'd15: r = "e";
			6'd16: r = "r";
			6'd17: r = "R";
			6'd18: r = "e";
			6'd19: r = "s";
			6'd20: r = "p";
			6'd21: r = "o";
			6'd22: r = "n";
			6'd23: r = "s";
			6'd24: r = "e";
			6'd25: r = "-";
			6'd26: r = "C";
			6'd27: r = "L";
			6'd28: r = "Z";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/atsms_front.sv =====
// Front end: accepts received bytes and classifies them for the parser.
module atsms_front (
	input  logic                  rx_valid,
	input  logic [7:0]            rx_byte,
	output logic                  rx_stall,
	input  logic                  q_full,
	output logic                  push,
	output atsms_pkg::byte_class_t push_cls
);

	assign rx_stall = q_full;
	assign push     = rx_valid && !q_full;

	always_comb begin
		push_cls.ch       = rx_byte;
		push_cls.is_plus  = (rx_byte == "+");
		push_cls.is_c     = (rx_byte == "C");
		push_cls.is_m     = (rx_byte == "M");
		push_cls.is_t     = (rx_byte == "T");
		push_cls.is_g     = (rx_byte == "G");
		push_cls.is_s     = (rx_byte == "S");
		push_cls.is_colon = (rx_byte == ":");
		push_cls.is_quote = (rx_byte == 8'h22);
		push_cls.is_cr    = (rx_byte == 8'h0D);
		push_cls.is_lf    = (rx_byte == 8'h0A);
		push_cls.is_o     = (rx_byte == "O");
		push_cls.is_k     = (rx_byte == "K");
	end

endmodule

// ===== rtl/atsms_queue.sv =====
// Two-entry queue of classified bytes between the front end and the parser.
module atsms_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  atsms_pkg::byte_class_t push_cls,
	input  logic                   pop,
	output logic                   empty,
	output logic                   full,
	output atsms_pkg::byte_class_t head_cls
);

	localparam int PTR_W = (atsms_pkg::QUEUE_DEPTH > 1) ? $clog2(atsms_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(atsms_pkg::QUEUE_DEPTH + 1);

	atsms_pkg::byte_class_t mem_q [atsms_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(atsms_pkg::QUEUE_DEPTH));
	assign head_cls = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(atsms_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(atsms_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/atsms_back.sv =====
// Back end: header matcher, message body parser and registered result stage.
`include "at_sms_response_parser_unit_defines.svh"

module atsms_back #(
	parameter int SENDER_MAX  = 32,
	parameter int STAMP_MAX   = 32,
	parameter int COMMAND_MAX = 64,
	parameter int DATA_MAX    = 128
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	input  atsms_pkg::byte_class_t head_cls,
	output logic                   pop,
	output logic                   res_valid,
	input  logic                   res_stall,
	output logic [2:0]             event_res,
	output logic [1:0]             field_id,
	output logic [7:0]             field_char,
	output logic                   overflow,
	output logic [3:0]             leds
);

	localparam logic [6:0] SENDER_LIM  = 7'(SENDER_MAX - 1);
	localparam logic [6:0] STAMP_LIM   = 7'(STAMP_MAX - 1);
	localparam logic [6:0] COMMAND_LIM = 7'(COMMAND_MAX - 1);
	localparam logic [6:0] DATA_LIM    = 7'(DATA_MAX - 1);

	logic [2:0] hp_q, n_hp;
	logic [1:0] kind_q, n_kind;
	logic [3:0] step_q, n_step;
	logic [6:0] fc_q, n_fc;
	logic [1:0] km_q, n_km;
	logic [5:0] kp_q, n_kp;
	logic       ov_q, n_ov;
	logic [3:0] lamp_q, n_lamp;

	logic            out_valid_q;
	atsms_pkg::event_t ev_q, o_ev;
	logic [1:0]      fid_q, o_fid;
	logic [7:0]      ch_q, o_ch;
	logic            ovo_q, o_ov;
	logic [3:0]      leds_q;

	logic            complete;
	logic            do_cap;
	logic [1:0]      cap_fid;
	logic            do_end;
	atsms_pkg::event_t end_ev;
	logic [1:0]      end_fid;
	logic [6:0]      cap_lim;
	logic            wifi_ok;
	logic            reg_ok;
	atsms_pkg::byte_class_t c;

	assign c   = head_cls;
	assign pop = !q_empty && (!out_valid_q || !res_stall);

	always_comb begin
		n_hp     = atsms_pkg::HDR_NONE;
		n_kind   = kind_q;
		n_step   = step_q;
		n_fc     = fc_q;
		n_km     = km_q;
		n_kp     = kp_q;
		n_ov     = ov_q;
		n_lamp   = lamp_q;
		o_ev     = atsms_pkg::EV_NONE;
		o_fid    = atsms_pkg::FLD_SENDER;
		o_ch     = 8'h00;
		do_cap   = 1'b0;
		cap_fid  = atsms_pkg::FLD_SENDER;
		do_end   = 1'b0;
		end_ev   = atsms_pkg::EV_FIELD_END;
		end_fid  = atsms_pkg::FLD_SENDER;
		cap_lim  = SENDER_LIM;
		wifi_ok  = km_q[0] && (kp_q == atsms_pkg::WIFI_LEN);
		reg_ok   = km_q[1] && (kp_q == atsms_pkg::REG_LEN);

		if (hp_q == atsms_pkg::HDR_NONE && c.is_plus) begin
			n_hp = atsms_pkg::HDR_PLUS;
		end else if (hp_q == atsms_pkg::HDR_PLUS && c.is_c) begin
			n_hp = atsms_pkg::HDR_C;
		end else if (hp_q == atsms_pkg::HDR_C && c.is_m) begin
			n_hp = atsms_pkg::HDR_M;
		end else if (hp_q == atsms_pkg::HDR_M && (c.is_t || c.is_g)) begin
			n_kind = c.is_t ? atsms_pkg::KIND_TEXT : atsms_pkg::KIND_SENT;
			n_hp   = atsms_pkg::HDR_KIND;
		end else if (hp_q == atsms_pkg::HDR_KIND &&
				((kind_q == atsms_pkg::KIND_TEXT && c.is_colon) ||
				(kind_q == atsms_pkg::KIND_SENT && c.is_s))) begin
			n_hp = atsms_pkg::HDR_FIVE;
		end else if (hp_q == atsms_pkg::HDR_FIVE && kind_q == atsms_pkg::KIND_SENT &&
				c.is_colon) begin
			n_hp = atsms_pkg::HDR_SIX;
		end

		complete = (n_hp == atsms_pkg::HDR_FIVE && n_kind == atsms_pkg::KIND_TEXT) ||
			(n_hp == atsms_pkg::HDR_SIX && n_kind == atsms_pkg::KIND_SENT);

		if (complete) begin
			n_hp   = atsms_pkg::HDR_NONE;
			n_fc   = 7'd0;
			n_ov   = 1'b0;
			n_km   = 2'b11;
			n_kp   = 6'd0;
			n_step = atsms_pkg::STEP_HEAD;
			n_lamp = 4'b1000;
			o_ev   = atsms_pkg::EV_HEADER;
		end else if (step_q != atsms_pkg::STEP_IDLE && n_kind == atsms_pkg::KIND_TEXT) begin
			if (step_q == atsms_pkg::STEP_HEAD) begin
				if (c.is_quote) begin
					n_step = atsms_pkg::STEP_SENDER;
				end
			end else if (step_q == atsms_pkg::STEP_SENDER) begin
				if (c.is_quote) begin
					n_step  = atsms_pkg::STEP_SKIP_FIRST;
					do_end  = 1'b1;
					end_fid = atsms_pkg::FLD_SENDER;
				end else begin
					do_cap  = 1'b1;
					cap_fid = atsms_pkg::FLD_SENDER;
				end
			end else if (step_q >= atsms_pkg::STEP_SKIP_FIRST &&
					step_q <= atsms_pkg::STEP_SKIP_LAST) begin
				if (c.is_quote) begin
					n_step = step_q + 4'd1;
				end
			end else if (step_q == atsms_pkg::STEP_STAMP) begin
				if (c.is_quote) begin
					n_step  = atsms_pkg::STEP_LINE_END;
					do_end  = 1'b1;
					end_fid = atsms_pkg::FLD_STAMP;
				end else begin
					do_cap  = 1'b1;
					cap_fid = atsms_pkg::FLD_STAMP;
				end
			end else if (step_q == atsms_pkg::STEP_LINE_END) begin
				if (c.is_lf) begin
					n_step = atsms_pkg::STEP_COMMAND;
					n_fc   = 7'd0;
					n_ov   = 1'b0;
					n_km   = 2'b11;
					n_kp   = 6'd0;
				end
			end else if (step_q == atsms_pkg::STEP_COMMAND) begin
				if (c.is_lf) begin
					n_step    = atsms_pkg::STEP_DATA;
					n_lamp[2] = 1'b1;
					do_end    = 1'b1;
					end_fid   = atsms_pkg::FLD_COMMAND;
				end else begin
					do_cap  = 1'b1;
					cap_fid = atsms_pkg::FLD_COMMAND;
				end
			end else begin
				if (wifi_ok || reg_ok) begin
					n_lamp[1] = 1'b1;
					if (c.is_cr) begin
						n_step  = atsms_pkg::STEP_IDLE;
						n_kind  = atsms_pkg::KIND_NONE;
						n_lamp  = 4'b0000;
						do_end  = 1'b1;
						end_ev  = wifi_ok ? atsms_pkg::EV_WIFI_DONE : atsms_pkg::EV_REG_DONE;
						end_fid = atsms_pkg::FLD_DATA;
					end else begin
						do_cap  = 1'b1;
						cap_fid = atsms_pkg::FLD_DATA;
					end
				end else begin
					n_step = atsms_pkg::STEP_IDLE;
					n_kind = atsms_pkg::KIND_NONE;
					n_lamp = 4'b0000;
					o_ev   = atsms_pkg::EV_ABORTED;
				end
			end
		end else if (step_q != atsms_pkg::STEP_IDLE && n_kind == atsms_pkg::KIND_SENT) begin
			if (c.is_cr && (step_q == atsms_pkg::STEP_SENT_CR1 ||
					step_q == atsms_pkg::STEP_SENT_CR2)) begin
				n_step = step_q + 4'd1;
			end else if (c.is_lf && (step_q == atsms_pkg::STEP_SENT_LF1 ||
					step_q == atsms_pkg::STEP_SENT_LF2)) begin
				n_step = step_q + 4'd1;
			end else if (c.is_o && step_q == atsms_pkg::STEP_SENT_O) begin
				n_step = atsms_pkg::STEP_SENT_K;
			end else if (c.is_k && step_q == atsms_pkg::STEP_SENT_K) begin
				n_step = atsms_pkg::STEP_IDLE;
				n_kind = atsms_pkg::KIND_NONE;
				n_lamp = 4'b0000;
				o_ev   = atsms_pkg::EV_MSG_SENT;
			end
		end

		case (cap_fid)
			atsms_pkg::FLD_SENDER:  cap_lim = SENDER_LIM;
			atsms_pkg::FLD_STAMP:   cap_lim = STAMP_LIM;
			atsms_pkg::FLD_COMMAND: cap_lim = COMMAND_LIM;
			default:                cap_lim = DATA_LIM;
		endcase

		if (do_cap) begin
			o_fid = cap_fid;
			if (fc_q < cap_lim) begin
				n_fc = fc_q + 7'd1;
				o_ev = atsms_pkg::EV_FIELD_CHAR;
				o_ch = c.ch;
				if (cap_fid == atsms_pkg::FLD_COMMAND) begin
					if (!(kp_q < atsms_pkg::WIFI_LEN && atsms_pkg::wifi_char(kp_q) == c.ch)) begin
						n_km[0] = 1'b0;
					end
					if (!(kp_q < atsms_pkg::REG_LEN && atsms_pkg::reg_char(kp_q) == c.ch)) begin
						n_km[1] = 1'b0;
					end
					if (kp_q < atsms_pkg::KW_POS_MAX) begin
						n_kp = kp_q + 6'd1;
					end
				end
			end else begin
				n_ov = 1'b1;
				if (cap_fid == atsms_pkg::FLD_COMMAND) begin
					n_km = 2'b00;
				end
			end
		end

		if (do_end) begin
			o_ev  = end_ev;
			o_fid = end_fid;
			n_fc  = 7'd0;
			n_ov  = 1'b0;
		end

		o_ov = do_end ? ov_q : n_ov;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q        <= atsms_pkg::HDR_NONE;
			kind_q      <= atsms_pkg::KIND_NONE;
			step_q      <= atsms_pkg::STEP_IDLE;
			fc_q        <= 7'd0;
			km_q        <= 2'b11;
			kp_q        <= 6'd0;
			ov_q        <= 1'b0;
			lamp_q      <= 4'b0000;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				hp_q        <= n_hp;
				kind_q      <= n_kind;
				step_q      <= n_step;
				fc_q        <= n_fc;
				km_q        <= n_km;
				kp_q        <= n_kp;
				ov_q        <= n_ov;
				lamp_q      <= n_lamp;
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ev_q   <= o_ev;
			fid_q  <= o_fid;
			ch_q   <= o_ch;
			ovo_q  <= o_ov;
			leds_q <= n_lamp;
		end
	end

	assign res_valid  = out_valid_q;
	assign event_res  = ev_q;
	assign field_id   = fid_q;
	assign field_char = ch_q;
	assign overflow   = ovo_q;
	assign leds       = leds_q;

	`ATSMS_ASSERT_NEXT(a_header_starts_body, pop && complete,
		step_q == atsms_pkg::STEP_HEAD && hp_q == atsms_pkg::HDR_NONE && lamp_q == 4'b1000,
		"Header request did not start the body parser")
	`ATSMS_ASSERT_ALWAYS(a_lamp_bit0_clear, !lamp_q[0], "Completion lamp left set")
	`ATSMS_ASSERT_ALWAYS(a_char_counted,
		!(out_valid_q && ev_q == atsms_pkg::EV_FIELD_CHAR) || fc_q != 7'd0,
		"Field character delivered without a count")
	`ATSMS_ASSERT_ALWAYS(a_end_returns_idle,
		!(out_valid_q && (ev_q == atsms_pkg::EV_MSG_SENT || ev_q == atsms_pkg::EV_ABORTED ||
		ev_q == atsms_pkg::EV_WIFI_DONE || ev_q == atsms_pkg::EV_REG_DONE)) ||
		(step_q == atsms_pkg::STEP_IDLE && kind_q == atsms_pkg::KIND_NONE),
		"Parser not idle after a closing request")

endmodule

// ===== rtl/at_sms_response_parser_unit.sv =====
// Top level of the modem response parser: front end, queue and parser back end.
//
// The rx channel takes one modem byte per request (rx_valid, rx_stall, rx_byte).
// Every accepted byte yields exactly one result on the res channel (res_valid,
// res_stall) carrying event_res, field_id, field_char, overflow and leds.
// Bytes are classified on entry and held in a two-entry queue; while res_stall
// is low, the parser back end takes one byte per cycle from the queue into a
// registered result stage. A byte is held in the queue and then in the result
// stage before its result shows, and the block sustains one byte per clock cycle
// while res_stall is low; the back end's per-byte state update sets that rate.
// When the receiver stalls, the current result holds, the queue fills, and
// rx_stall rises once both queue entries are taken; no byte or result is lost.
// Reset clears the header matcher, the body parser, the lamps and the queue,
// and leaves no result pending. The field length limits are set by the
// SENDER_MAX, STAMP_MAX, COMMAND_MAX and DATA_MAX parameters; characters past
// a limit are dropped and reported through overflow.
module at_sms_response_parser_unit #(
	parameter int SENDER_MAX  = 32,
	parameter int STAMP_MAX   = 32,
	parameter int COMMAND_MAX = 64,
	parameter int DATA_MAX    = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [2:0] event_res,
	output logic [1:0] field_id,
	output logic [7:0] field_char,
	output logic       overflow,
	output logic [3:0] leds
);

	logic                   push;
	logic                   pop;
	logic                   q_empty;
	logic                   q_full;
	atsms_pkg::byte_class_t push_cls;
	atsms_pkg::byte_class_t head_cls;

	atsms_front u_front (
		.rx_valid (rx_valid),
		.rx_byte  (rx_byte),
		.rx_stall (rx_stall),
		.q_full   (q_full),
		.push     (push),
		.push_cls (push_cls)
	);

	atsms_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cls (push_cls),
		.pop      (pop),
		.empty    (q_empty),
		.full     (q_full),
		.head_cls (head_cls)
	);

	atsms_back #(
		.SENDER_MAX  (SENDER_MAX),
		.STAMP_MAX   (STAMP_MAX),
		.COMMAND_MAX (COMMAND_MAX),
		.DATA_MAX    (DATA_MAX)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.head_cls   (head_cls),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.event_res  (event_res),
		.field_id   (field_id),
		.field_char (field_char),
		.overflow   (overflow),
		.leds       (leds)
	);

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the modem response parser: byte stream in, one checked result per byte.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import atsms_pkg::*;

	localparam int SENDER_MAX  = 32;
	localparam int STAMP_MAX   = 32;
	localparam int COMMAND_MAX = 64;
	localparam int DATA_MAX    = 128;

	localparam string WIFI_WORD = "WiFiConnect";
	localparam string REG_WORD  = {"PL", "MS-UnitRegisterResponse-C", "LZ"};

	localparam logic [7:0] QUOTE = 8'h22;
	localparam logic [7:0] CR    = 8'h0D;
	localparam logic [7:0] LF    = 8'h0A;

	localparam logic [3:0] SENT_CR1 = STEP_HEAD;
	localparam logic [3:0] SENT_LF1 = STEP_HEAD + 4'd1;
	localparam logic [3:0] SENT_CR2 = STEP_HEAD + 4'd2;
	localparam logic [3:0] SENT_LF2 = STEP_HEAD + 4'd3;
	localparam logic [3:0] SENT_O   = STEP_HEAD + 4'd4;
	localparam logic [3:0] SENT_K   = STEP_HEAD + 4'd5;

	localparam int TEXT_WIFI = 0;
	localparam int TEXT_REG  = 1;
	localparam int TEXT_NEAR = 2;
	localparam int TEXT_RAND = 3;

	typedef struct {
		event_t     ev;
		logic [1:0] fid;
		logic [7:0] ch;
		logic       ovf;
		logic [3:0] leds;
	} result_t;

	class response_scoreboard;
		logic [2:0] hdr_pos;
		logic [1:0] kind;
		logic [3:0] step;
		logic [6:0] fcount;
		logic [1:0] kw_alive;
		logic [5:0] kw_pos;
		logic       ovf_seen;
		logic [3:0] lamps;
		result_t    awaited[$];
		int         errors;
		int         checked;

		function new();
			hdr_pos = '0;
			kind = KIND_NONE;
			step = STEP_IDLE;
			fcount = '0;
			kw_alive = 2'b11;
			kw_pos = '0;
			ovf_seen = 1'b0;
			lamps = '0;
			errors = 0;
			checked = 0;
		endfunction

		function result_t outcome(event_t ev, logic [1:0] fid, logic [7:0] ch, logic ovf);
			result_t r;
			r.ev = ev;
			r.fid = fid;
			r.ch = ch;
			r.ovf = ovf;
			r.leds = lamps;
			return r;
		endfunction

		function result_t store_char(logic [1:0] fid, logic [7:0] c);
			int lim;
			case (fid)
				FLD_SENDER:  lim = SENDER_MAX - 1;
				FLD_STAMP:   lim = STAMP_MAX - 1;
				FLD_COMMAND: lim = COMMAND_MAX - 1;
				default:     lim = DATA_MAX - 1;
			endcase
			if (int'(fcount) < lim) begin
				fcount = fcount + 7'd1;
				if (fid == FLD_COMMAND) begin
					if (kw_pos >= WIFI_WORD.len() || WIFI_WORD[kw_pos] != c)
						kw_alive[0] = 1'b0;
					if (kw_pos >= REG_WORD.len() || REG_WORD[kw_pos] != c)
						kw_alive[1] = 1'b0;
					if (kw_pos < KW_POS_MAX)
						kw_pos = kw_pos + 6'd1;
				end
				return outcome(EV_FIELD_CHAR, fid, c, ovf_seen);
			end
			ovf_seen = 1'b1;
			if (fid == FLD_COMMAND)
				kw_alive = 2'b00;
			return outcome(EV_NONE, fid, 8'h00, 1'b1);
		endfunction

		function result_t close_field(event_t ev, logic [1:0] fid);
			logic ov;
			ov = ovf_seen;
			fcount = '0;
			ovf_seen = 1'b0;
			return outcome(ev, fid, 8'h00, ov);
		endfunction

		function result_t predict(logic [7:0] c);
			logic [3:0] st;
			logic       wifi;
			logic       reg_hit;
			if (hdr_pos == 3'd0 && c == "+")
				hdr_pos = HDR_PLUS;
			else if (hdr_pos == HDR_PLUS && c == "C")
				hdr_pos = HDR_C;
			else if (hdr_pos == HDR_C && c == "M")
				hdr_pos = HDR_M;
			else if (hdr_pos == HDR_M && (c == "T" || c == "G")) begin
				kind = (c == "T") ? KIND_TEXT : KIND_SENT;
				hdr_pos = HDR_KIND;
			end else if (hdr_pos == HDR_KIND &&
					((kind == KIND_TEXT && c == ":") || (kind == KIND_SENT && c == "S")))
				hdr_pos = HDR_FIVE;
			else if (hdr_pos == HDR_FIVE && kind == KIND_SENT && c == ":")
				hdr_pos = HDR_SIX;
			else
				hdr_pos = 3'd0;

			if ((hdr_pos == HDR_FIVE && kind == KIND_TEXT) ||
					(hdr_pos == HDR_SIX && kind == KIND_SENT)) begin
				hdr_pos = 3'd0;
				fcount = '0;
				ovf_seen = 1'b0;
				kw_alive = 2'b11;
				kw_pos = '0;
				step = STEP_HEAD;
				lamps = 4'b1000;
				return outcome(EV_HEADER, FLD_SENDER, 8'h00, 1'b0);
			end

			st = step;
			if (st >= STEP_HEAD && kind == KIND_TEXT) begin
				if (st == STEP_HEAD && c == QUOTE)
					step = STEP_SENDER;
				else if (st == STEP_SENDER) begin
					if (c == QUOTE) begin
						step = STEP_SKIP_FIRST;
						return close_field(EV_FIELD_END, FLD_SENDER);
					end
					return store_char(FLD_SENDER, c);
				end else if (st >= STEP_SKIP_FIRST && st <= STEP_SKIP_LAST && c == QUOTE)
					step = st + 4'd1;
				else if (st == STEP_STAMP) begin
					if (c == QUOTE) begin
						step = STEP_LINE_END;
						return close_field(EV_FIELD_END, FLD_STAMP);
					end
					return store_char(FLD_STAMP, c);
				end else if (st == STEP_LINE_END && c == LF) begin
					step = STEP_COMMAND;
					fcount = '0;
					ovf_seen = 1'b0;
					kw_alive = 2'b11;
					kw_pos = '0;
				end else if (st == STEP_COMMAND) begin
					if (c == LF) begin
						step = STEP_DATA;
						lamps = lamps | 4'b0100;
						return close_field(EV_FIELD_END, FLD_COMMAND);
					end
					return store_char(FLD_COMMAND, c);
				end else if (st >= STEP_DATA) begin
					wifi = kw_alive[0] && kw_pos == WIFI_WORD.len();
					reg_hit = kw_alive[1] && kw_pos == REG_WORD.len();
					if (wifi || reg_hit) begin
						lamps = lamps | 4'b0010;
						if (c == CR) begin
							step = STEP_IDLE;
							kind = KIND_NONE;
							lamps = '0;
							if (wifi)
								return close_field(EV_WIFI_DONE, FLD_DATA);
							return close_field(EV_REG_DONE, FLD_DATA);
						end
						return store_char(FLD_DATA, c);
					end
					step = STEP_IDLE;
					kind = KIND_NONE;
					lamps = '0;
					return outcome(EV_ABORTED, FLD_SENDER, 8'h00, ovf_seen);
				end
			end else if (st >= STEP_HEAD && kind == KIND_SENT) begin
				if (c == CR && (st == SENT_CR1 || st == SENT_CR2))
					step = st + 4'd1;
				else if (c == LF && (st == SENT_LF1 || st == SENT_LF2))
					step = st + 4'd1;
				else if (c == "O" && st == SENT_O)
					step = SENT_K;
				else if (c == "K" && st == SENT_K) begin
					step = STEP_IDLE;
					kind = KIND_NONE;
					lamps = '0;
					return outcome(EV_MSG_SENT, FLD_SENDER, 8'h00, ovf_seen);
				end
			end
			return outcome(EV_NONE, FLD_SENDER, 8'h00, ovf_seen);
		endfunction

		function void note_byte(logic [7:0] c);
			awaited.push_back(predict(c));
		endfunction

		function void check_result(logic [2:0] ev, logic [1:0] fid, logic [7:0] ch, logic ovf,
				logic [3:0] leds);
			result_t want;
			checked++;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Result %0d arrived with no request outstanding: event %0d", checked,
						ev);
				return;
			end
			want = awaited.pop_front();
			if (ev !== want.ev || fid !== want.fid || ch !== want.ch || ovf !== want.ovf ||
					leds !== want.leds) begin
				errors++;
				if (errors <= 10)
					$display("Result %0d: expected event %0d field %0d char %02h overflow %0d leds %h, got event %0d field %0d char %02h overflow %0d leds %h",
						checked, want.ev, want.fid, want.ch, want.ovf, want.leds,
						ev, fid, ch, ovf, leds);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       rx_valid = 1'b0;
	logic       rx_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [2:0] event_res;
	logic [1:0] field_id;
	logic [7:0] field_char;
	logic       overflow;
	logic [3:0] leds;

	response_scoreboard sb = new();
	logic [7:0] byte_plan[$];
	bit         quiet = 1'b1;
	int         bytes_sent = 0;

	at_sms_response_parser_unit #(
		.SENDER_MAX(SENDER_MAX),
		.STAMP_MAX(STAMP_MAX),
		.COMMAND_MAX(COMMAND_MAX),
		.DATA_MAX(DATA_MAX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.event_res(event_res),
		.field_id(field_id),
		.field_char(field_char),
		.overflow(overflow),
		.leds(leds)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && rx_valid && !rx_stall)
			sb.note_byte(rx_byte);
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(event_res, field_id, field_char, overflow, leds);
	end

	function automatic int idle_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int field_len(int lim);
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(0, 10);
		if (r < 92)
			return $urandom_range(lim - 2, lim + 1);
		return $urandom_range(lim + 2, lim + 8);
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			byte_plan.push_back(s[i]);
	endfunction

	function automatic void add_chars(int n);
		logic [7:0] c;
		for (int i = 0; i < n; i++) begin
			do
				c = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
					8'($urandom_range(32, 126));
			while (c == QUOTE || c == "+" || c == CR || c == LF);
			byte_plan.push_back(c);
		end
	endfunction

	function automatic string header_piece();
		case ($urandom_range(0, 9))
			0: return "+";
			1: return "+C";
			2: return "+CM";
			3: return "+CMT";
			4: return "+CMG";
			5: return "+CMGS";
			6: return "++CMT:";
			7: return "+CMGT:";
			8: return "+CMT:";
			default: return "+CMGS:";
		endcase
	endfunction

	function automatic string near_miss();
		string s;
		int    pos;
		s = ($urandom_range(0, 1) == 0) ? WIFI_WORD : REG_WORD;
		case ($urandom_range(0, 2))
			0: begin
				pos = $urandom_range(0, s.len() - 1);
				s.putc(pos, s[pos] ^ 8'h20);
			end
			1: s = s.substr(0, s.len() - 2);
			default: s = {s, "x"};
		endcase
		return s;
	endfunction

	function automatic void add_text_message(int cmd, bit nest);
		add_text("+CMT: \"");
		add_chars(field_len(SENDER_MAX - 1));
		if (nest) begin
			add_text(header_piece());
			add_chars($urandom_range(0, 3));
		end
		add_text("\",\"\",\"");
		add_chars(field_len(STAMP_MAX - 1));
		add_text("\"\r\n");
		case (cmd)
			TEXT_WIFI: add_text(WIFI_WORD);
			TEXT_REG:  add_text(REG_WORD);
			TEXT_NEAR: add_text(near_miss());
			default:   add_chars(field_len(COMMAND_MAX - 1));
		endcase
		if ($urandom_range(0, 9) == 0)
			add_text("\r");
		add_text("\n");
		add_chars(field_len(DATA_MAX - 1));
		add_text("\r");
	endfunction

	function automatic void add_sent_result();
		add_text("+CMGS: ");
		repeat ($urandom_range(1, 3))
			byte_plan.push_back(8'($urandom_range(48, 57)));
		add_text("\r\n\r\nOK");
		if ($urandom_range(0, 1) == 0)
			add_text("\r\n");
	endfunction

	function automatic void add_random_sequence();
		int r;
		int mark;
		int cut;
		int pick;
		mark = byte_plan.size();
		r = $urandom_range(0, 99);
		pick = $urandom_range(0, 99);
		if (r < 45)
			add_text_message(pick < 35 ? TEXT_WIFI : pick < 70 ? TEXT_REG :
				pick < 85 ? TEXT_NEAR : TEXT_RAND, 1'b0);
		else if (r < 63)
			add_sent_result();
		else if (r < 75) begin
			add_text(header_piece());
			add_chars($urandom_range(0, 4));
		end else if (r < 87) begin
			repeat ($urandom_range(1, 16))
				byte_plan.push_back(8'($urandom_range(0, 255)));
		end else
			add_text_message($urandom_range(TEXT_WIFI, TEXT_NEAR), 1'b1);
		if (r < 63 && byte_plan.size() - mark > 2) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				cut = $urandom_range(1, byte_plan.size() - mark - 1);
				repeat (cut)
					void'(byte_plan.pop_back());
			end else if (pick < 24)
				byte_plan[$urandom_range(mark, byte_plan.size() - 1)] = 8'($urandom_range(0, 255));
		end
	endfunction

	task automatic send_plan();
		logic [7:0] b;
		int         gap;
		while (byte_plan.size() != 0) begin
			b = byte_plan.pop_front();
			gap = idle_len();
			repeat (gap) begin
				@(negedge clk);
				rx_valid = 1'b0;
				rx_byte = 8'($urandom_range(0, 255));
			end
			@(negedge clk);
			rx_valid = 1'b1;
			rx_byte = b;
			do
				@(posedge clk);
			while (rx_stall);
			bytes_sent++;
		end
	endtask

	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				res_stall = 1'b1;
				stall_left--;
			end else begin
				res_stall = 1'b0;
				if ($urandom_range(0, 3) == 0)
					stall_left = idle_len();
			end
		end
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int wait_cycles;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		byte_plan.push_back(8'h00);
		byte_plan.push_back(8'hFF);
		add_text("++CMT:");
		add_text("+CMGS: 5\r\n\r\nOK");
		add_text({"+CMT: \"+1\",\"\",\"t\"\r\n", WIFI_WORD, "\nab\r"});
		add_text({"+CMT: \"\",\"\",\"\"\n", REG_WORD, "\n\r"});
		add_text("+CMT: \"a\",\"\",\"b\"\nxyz\nQ");
		add_text("+CMT: \"ab+CMGx\r\n\r\nOK");
		send_plan();

		while (bytes_sent < 1900) begin
			quiet = ($urandom_range(0, 7) == 0);
			add_random_sequence();
			send_plan();
		end
		@(negedge clk);
		rx_valid = 1'b0;
		quiet = 1'b1;

		wait_cycles = 0;
		while (sb.awaited.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (8) @(posedge clk);
		if (sb.awaited.size() != 0) begin
			sb.errors++;
			$display("%0d expected results never arrived", sb.awaited.size());
		end
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/atsms_pkg.sv
rtl/atsms_front.sv
rtl/atsms_queue.sv
rtl/atsms_back.sv
rtl/at_sms_response_parser_unit.sv
test/tb.sv
